// ===== rtl/core/lsb_text_embed_extract_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LSB_TEXT_EMBED_EXTRACT_DEFINES_SVH
`define LSB_TEXT_EMBED_EXTRACT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define LTE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define LTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lte_pkg.sv =====
package lte_pkg;

	localparam int CARRIERS = 8;
	localparam int BYTE_W   = 8;
	localparam int ROLE_W   = 2;
	localparam int TDATA_W  = (CARRIERS + 1) * BYTE_W;
	localparam int TUSER_IN_W  = 1;
	localparam int TUSER_OUT_W = ROLE_W;
	localparam int ADDR_W   = 3;

	// Group roles, which double as the phase codes.
	localparam logic [ROLE_W-1:0] ROLE_HEADER  = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_PASS    = 2'd2;

	// Register byte addresses.
	localparam logic [ADDR_W-1:0] REG_MODE_ADDR = 3'd0;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	// Per-group decision from the control unit to the lanes and the output stage.
	typedef struct packed {
		logic [ROLE_W-1:0] role;
		logic              last;
		logic              embed;
	} ctrl_t;

endpackage

// ===== rtl/core/lte_lane.sv =====
// One carrier byte: optional LSB replacement and LSB tap.
module lte_lane (
	input  lte_pkg::byte_t carrier,
	input  logic           embed,
	input  logic           msg_bit,
	output lte_pkg::byte_t data_out,
	output logic           lsb
);

	assign data_out = embed ? {carrier[lte_pkg::BYTE_W-1:1], msg_bit} : carrier;
	assign lsb      = carrier[0];

endmodule

// ===== rtl/core/lte_ctrl.sv =====
// Phase tracker: header, payload count-down and pass-through.
module lte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           start,
	input  logic           mode,
	input  lte_pkg::byte_t msg,
	input  lte_pkg::byte_t decoded,
	output lte_pkg::ctrl_t ctrl
);

	logic [lte_pkg::ROLE_W-1:0] phase_q;
	logic [lte_pkg::ROLE_W-1:0] phase_d;
	lte_pkg::byte_t             left_q;
	lte_pkg::byte_t             left_d;
	lte_pkg::byte_t             len;
	logic [lte_pkg::ROLE_W-1:0] role;
	logic                       last;

	assign len = (mode == lte_pkg::MODE_EXTRACT) ? decoded : msg;

	always_comb begin
		role    = start ? lte_pkg::ROLE_HEADER : phase_q;
		last    = 1'b0;
		phase_d = lte_pkg::ROLE_PASS;
		left_d  = left_q;
		unique case (role)
			lte_pkg::ROLE_HEADER: begin
				if (len == '0) begin
					last   = 1'b1;
					left_d = '0;
				end else begin
					phase_d = lte_pkg::ROLE_PAYLOAD;
					left_d  = len;
				end
			end
			lte_pkg::ROLE_PAYLOAD: begin
				// A count of zero here is treated as the final group.
				if (left_q <= lte_pkg::byte_t'(1)) begin
					last   = 1'b1;
					left_d = '0;
				end else begin
					phase_d = lte_pkg::ROLE_PAYLOAD;
					left_d  = left_q - lte_pkg::byte_t'(1);
				end
			end
			default: begin
				role = lte_pkg::ROLE_PASS;
			end
		endcase
	end

	assign ctrl.role  = role;
	assign ctrl.last  = last;
	assign ctrl.embed = (role != lte_pkg::ROLE_PASS) && (mode == lte_pkg::MODE_EMBED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lte_pkg::ROLE_HEADER;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== rtl/core/lsb_text_embed_extract.sv =====
// Each result is registered in the output buffer; the lanes and the control decode are combinational.
// Throughput: one group per cycle while s_tready is high; the phase and count registers form the loop.
// A two-entry output buffer lets one more group in while the master side stalls.
// Reset (arst_n low, asynchronous) selects embed mode, returns to the header phase
// with a zero count and empties the output buffer.
module lsb_text_embed_extract (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB-style configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lte_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// Slave side: carrier groups.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// carrier_0 [7:0] ... carrier_7 [63:56], message_byte [71:64]
	input  logic [lte_pkg::TDATA_W-1:0]         s_tdata,
	// start_of_image [0]
	input  logic [lte_pkg::TUSER_IN_W-1:0]      s_tuser,
	// Master side: processed groups.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_0 [7:0] ... out_7 [63:56], decoded_byte [71:64]
	output logic [lte_pkg::TDATA_W-1:0]         m_tdata,
	// group_role [1:0]
	output logic [lte_pkg::TUSER_OUT_W-1:0]     m_tuser,
	// last_message_group
	output logic                                m_tlast
);

	localparam int RES_W = lte_pkg::TDATA_W + lte_pkg::TUSER_OUT_W + 1;

	logic                         mode_q;
	logic                         in_fire;
	logic                         out_free;
	lte_pkg::ctrl_t               ctrl;
	lte_pkg::byte_t               msg;
	logic [lte_pkg::CARRIERS-1:0] lsbs;
	lte_pkg::byte_t               decoded;
	logic [lte_pkg::CARRIERS*lte_pkg::BYTE_W-1:0] lanes_out;
	logic [RES_W-1:0]             result;
	logic [RES_W-1:0]             out_q;
	logic [RES_W-1:0]             skid_q;
	logic                         out_v_q;
	logic                         skid_v_q;

	// The configuration register. Writes to any address other than the mode
	// register are dropped; reads of those addresses return zero.
	assign pready = 1'b1;
	assign prdata = (paddr == lte_pkg::REG_MODE_ADDR) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lte_pkg::MODE_EMBED;
		end else if (psel && penable && pwrite && pready &&
				paddr == lte_pkg::REG_MODE_ADDR) begin
			mode_q <= pwdata[0];
		end
	end

	// Input side is ready as long as the skid entry is free.
	assign s_tready = !skid_v_q;
	assign in_fire  = s_tvalid && s_tready;
	assign msg      = s_tdata[lte_pkg::TDATA_W-1 -: lte_pkg::BYTE_W];

	// Lane i handles carrier i, which carries message bit 7-i and contributes
	// bit 7-i of the decoded byte, so carrier 0 ends up as the MSB.
	for (genvar i = 0; i < lte_pkg::CARRIERS; i++) begin : g_lane
		lte_lane u_lane (
			.carrier  (s_tdata[i*lte_pkg::BYTE_W +: lte_pkg::BYTE_W]),
			.embed    (ctrl.embed),
			.msg_bit  (msg[lte_pkg::CARRIERS-1-i]),
			.data_out (lanes_out[i*lte_pkg::BYTE_W +: lte_pkg::BYTE_W]),
			.lsb      (lsbs[lte_pkg::CARRIERS-1-i])
		);
	end

	assign decoded = lsbs;

	// The control unit sees the gathered LSBs, since in extract mode the
	// header length comes from the carriers themselves.
	lte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_fire),
		.start   (s_tuser[0]),
		.mode    (mode_q),
		.msg     (msg),
		.decoded (decoded),
		.ctrl    (ctrl)
	);

	// Merge the lane outputs with the decoded byte and the control decision.
	assign result = {ctrl.last, ctrl.role, decoded, lanes_out};

	// Two-entry output buffer. The output register is refilled from the skid
	// entry first, so transaction order is kept. While the skid entry is full
	// the input side is stalled, so no new result arrives in that case.
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= result;
			end
		end else if (in_fire) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q[lte_pkg::TDATA_W-1:0];
	assign m_tuser  = out_q[lte_pkg::TDATA_W +: lte_pkg::TUSER_OUT_W];
	assign m_tlast  = out_q[RES_W-1];

endmodule

// ===== rtl/core/lte_checker.sv =====
`include "lsb_text_embed_extract_defines.svh"

// Port-level checks of the block.
module lte_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lte_pkg::TDATA_W-1:0]     m_tdata,
	input logic [lte_pkg::TUSER_OUT_W-1:0] m_tuser,
	input logic                            m_tlast
);

	`LTE_ASSERT(a_role_code, !m_tvalid || m_tuser == lte_pkg::ROLE_HEADER || m_tuser == lte_pkg::ROLE_PAYLOAD || m_tuser == lte_pkg::ROLE_PASS, "invalid group role on master side")
	`LTE_ASSERT(a_last_not_pass, !(m_tvalid && m_tlast) || m_tuser != lte_pkg::ROLE_PASS, "last flag on a pass-through group")
	`LTE_ASSERT(a_stall_means_full, s_tready || m_tvalid, "input stalled with an empty output register")
	`LTE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transaction changed")

endmodule

bind lsb_text_embed_extract lte_checker u_lte_checker (.*);

// ===== dv/lte_tb_pkg.sv =====
package lte_tb_pkg;
	import lte_pkg::*;

	// One expected master-side transaction.
	typedef struct packed {
		logic [TDATA_W-1:0] data;
		logic [ROLE_W-1:0]  role;
		logic               last;
	} group_result_t;

	class lte_scoreboard;
		logic              mode;
		logic [ROLE_W-1:0] phase;
		byte_t             groups_left;
		group_result_t     expected_q[$];
		int                mismatches;
		int                role_count[3];
		int                extract_groups;

		function new();
			mode           = MODE_EMBED;
			phase          = ROLE_HEADER;
			groups_left    = '0;
			mismatches     = 0;
			extract_groups = 0;
			foreach (role_count[i]) role_count[i] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string what, logic [TDATA_W-1:0] want_v,
				logic [TDATA_W-1:0] got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
		endfunction

		// Works out the result of one accepted slave-side transaction and advances
		// the phase and the payload count.
		function void note_group(logic [TDATA_W-1:0] data, logic sof);
			byte_t             carrier;
			byte_t             msg;
			byte_t             lsbs;
			byte_t             msg_len;
			logic [ROLE_W-1:0] role;
			logic              embed_now;
			group_result_t     want;
			int                i;

			lsbs = '0;
			for (i = 0; i < CARRIERS; i++)
				lsbs = {lsbs[BYTE_W-2:0], data[BYTE_W*i]};
			msg = data[TDATA_W-1 -: BYTE_W];

			if (sof)
				phase = ROLE_HEADER;
			role = (phase == ROLE_HEADER || phase == ROLE_PAYLOAD) ? phase : ROLE_PASS;
			embed_now = (role != ROLE_PASS) && (mode == MODE_EMBED);
			if (mode == MODE_EXTRACT)
				extract_groups++;

			for (i = 0; i < CARRIERS; i++) begin
				carrier = data[BYTE_W*i +: BYTE_W];
				if (embed_now)
					carrier[0] = msg[CARRIERS-1-i];
				want.data[BYTE_W*i +: BYTE_W] = carrier;
			end
			want.data[TDATA_W-1 -: BYTE_W] = lsbs;
			want.role = role;
			want.last = 1'b0;

			case (role)
				ROLE_HEADER: begin
					msg_len = (mode == MODE_EXTRACT) ? lsbs : msg;
					if (msg_len == 0) begin
						want.last   = 1'b1;
						phase       = ROLE_PASS;
						groups_left = '0;
					end else begin
						phase       = ROLE_PAYLOAD;
						groups_left = msg_len;
					end
				end
				ROLE_PAYLOAD: begin
					if (groups_left <= 1) begin
						want.last   = 1'b1;
						groups_left = '0;
						phase       = ROLE_PASS;
					end else begin
						groups_left = groups_left - 1'b1;
					end
				end
				default: begin
					phase = ROLE_PASS;
				end
			endcase
			expected_q.push_back(want);
		endfunction

		function void check_group(logic [TDATA_W-1:0] data, logic [ROLE_W-1:0] role,
				logic last);
			group_result_t want;
			int            i;

			if (expected_q.size() == 0) begin
				report("unexpected result", '0, data);
				return;
			end
			want = expected_q.pop_front();
			for (i = 0; i < CARRIERS; i++)
				if (data[BYTE_W*i +: BYTE_W] !== want.data[BYTE_W*i +: BYTE_W])
					report($sformatf("out_%0d", i), want.data[BYTE_W*i +: BYTE_W],
						data[BYTE_W*i +: BYTE_W]);
			if (data[TDATA_W-1 -: BYTE_W] !== want.data[TDATA_W-1 -: BYTE_W])
				report("decoded_byte", want.data[TDATA_W-1 -: BYTE_W], data[TDATA_W-1 -: BYTE_W]);
			if (role !== want.role)
				report("group_role", want.role, role);
			if (last !== want.last)
				report("last_message_group", want.last, last);
			role_count[want.role]++;
		endfunction
	endclass

endpackage

// ===== dv/tb_lsb_text_embed_extract.sv =====
module tb_lsb_text_embed_extract;
	timeunit 1ns;
	timeprecision 1ps;

	import lte_pkg::*;
	import lte_tb_pkg::*;

	// Roughly how many slave-side transactions the run sends before it winds down.
	localparam int TARGET_GROUPS = 1050;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	// carrier_0 [7:0] ... carrier_7 [63:56], message_byte [71:64]
	logic [TDATA_W-1:0]     s_tdata;
	// start_of_image [0]
	logic [TUSER_IN_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// out_0 [7:0] ... out_7 [63:56], decoded_byte [71:64]
	logic [TDATA_W-1:0]     m_tdata;
	// group_role [1:0]
	logic [TUSER_OUT_W-1:0] m_tuser;
	logic                   m_tlast;

	lte_scoreboard sb = new();

	int   groups_sent;
	int   phase_end;
	int   mode_writes;
	bit   send_no_gaps;
	bit   recv_no_gaps;
	logic cur_mode;

	lsb_text_embed_extract u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Both handshakes are observed at the rising edge. The input side is noted
	// first, so the expectation queue already holds everything the block could
	// legally be returning at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_group(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready)
				sb.check_group(m_tdata, m_tuser, m_tlast);
		end
	end

	// Random carrier bytes around a chosen message byte. When the length has to
	// come from the carriers, their LSBs are overwritten with it, carrier 0
	// taking the most significant bit.
	function automatic logic [TDATA_W-1:0] make_group(byte_t msg, bit set_lsbs, byte_t lsbs);
		logic [TDATA_W-1:0] g;
		int                 i;

		g = {msg, $urandom(), $urandom()};
		if (set_lsbs)
			for (i = 0; i < CARRIERS; i++)
				g[BYTE_W*i] = lsbs[CARRIERS-1-i];
		return g;
	endfunction

	// Sends one slave-side transaction. Every task here starts and ends just
	// after a falling edge, so each input changes only there. The sender inserts
	// a random idle gap before each transaction, except during stretches
	// where it streams back to back.
	task automatic send_group(logic [TDATA_W-1:0] data, logic sof);
		int gap;

		gap = send_no_gaps ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 29) == 0)
			send_no_gaps = !send_no_gaps;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= sof;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		groups_sent++;
	endtask

	// Drops valid and lets the block drain completely. Every transaction yields
	// exactly one result, so an empty queue plus a short pause means idle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Writes the mode register, then reads it straight back. The write happens
	// at the edge that closes the access cycle, while the block is idle, so the
	// predictor can switch at the same point.
	task automatic write_mode(logic m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MODE_ADDR;
		pwdata  <= {31'b0, m};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.mode  = m;
		cur_mode = m;
		mode_writes++;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, m})
			sb.report("mode read-back", {31'b0, m}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// One message as the block expects it: a header that normally carries the
	// start flag, then the payload characters, then a few pass-through groups.
	// A small share of messages are broken off early or lose their start flag,
	// and stray start flags land inside payload and pass-through.
	task automatic send_message();
		int pick;
		int msg_len;
		int i;

		pick = $urandom_range(0, 99);
		if (pick < 8)
			msg_len = 0;
		else if (pick < 18)
			msg_len = $urandom_range(13, 255);
		else
			msg_len = $urandom_range(1, 12);

		// Embed mode takes the length from message_byte, extract mode from the
		// carrier LSBs; the other source gets random content.
		if (cur_mode == MODE_EMBED)
			send_group(make_group(byte_t'(msg_len), 1'b0, '0), $urandom_range(0, 9) != 0);
		else
			send_group(make_group(byte_t'($urandom), 1'b1, byte_t'(msg_len)),
				$urandom_range(0, 9) != 0);

		for (i = 0; i < msg_len; i++) begin
			if ($urandom_range(0, 39) == 0)
				return;
			send_group(make_group(byte_t'($urandom), 1'b0, '0), $urandom_range(0, 49) == 0);
		end
		repeat ($urandom_range(0, 3))
			send_group(make_group(byte_t'($urandom), 1'b0, '0), $urandom_range(0, 15) == 0);
	endtask

	// The master side stalls for a random gap before each result,
	// with its own stretches of constant readiness.
	initial begin
		int gap;

		m_tready     = 1'b0;
		recv_no_gaps = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = recv_no_gaps ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 29) == 0)
				recv_no_gaps = !recv_no_gaps;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// The slowest legal run takes far less than 5 ms, which leaves more than
	// ten times the margin.
	initial begin
		#5000000;
		$display("Timeout with %0d results still expected.", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		groups_sent  = 0;
		mode_writes  = 0;
		send_no_gaps = 1'b0;
		cur_mode     = MODE_EMBED;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part in embed mode. The very first group carries no start
		// flag: after reset the block is already waiting for a header.
		write_mode(MODE_EMBED);
		send_group({8'd2, {CARRIERS{8'hFF}}}, 1'b0);
		send_group({8'hFF, {CARRIERS{8'h00}}}, 1'b0);
		send_group({8'h00, {CARRIERS{8'hFF}}}, 1'b0);
		send_group({8'h5A, {CARRIERS{8'hAA}}}, 1'b0);
		// A zero length is flagged last on the header itself.
		send_group({8'h00, {CARRIERS{8'h55}}}, 1'b1);
		send_group({8'hFF, {CARRIERS{8'h81}}}, 1'b0);
		// Longest message, abandoned after one character by a fresh start.
		send_group({8'hFF, {CARRIERS{8'h7E}}}, 1'b1);
		send_group(make_group(8'hA5, 1'b0, '0), 1'b0);
		send_group(make_group(8'd1, 1'b0, '0), 1'b1);
		send_group(make_group(8'h3C, 1'b0, '0), 1'b0);

		// Extract mode: the length comes from the carrier LSBs, and message_byte
		// is set to values that would give a different length if it were used.
		wait_idle();
		write_mode(MODE_EXTRACT);
		send_group(make_group(8'hFF, 1'b1, 8'd0), 1'b1);
		send_group(make_group(8'hFF, 1'b0, '0), 1'b0);
		send_group(make_group(8'hFF, 1'b1, 8'd3), 1'b1);
		repeat (3)
			send_group(make_group(byte_t'($urandom), 1'b0, '0), 1'b0);
		send_group(make_group(8'h00, 1'b0, '0), 1'b0);
		send_group(make_group(8'h00, 1'b1, 8'hFF), 1'b1);
		send_group(make_group(8'h00, 1'b0, '0), 1'b0);

		// Switch back to embed in the middle of that message; the count goes on
		// and the next characters get embedded.
		wait_idle();
		write_mode(MODE_EMBED);
		send_group(make_group(8'hC3, 1'b0, '0), 1'b0);
		send_group(make_group(8'h18, 1'b0, '0), 1'b0);
		send_group(make_group(8'h00, 1'b0, '0), 1'b1);

		// Random part in phases of at least 50 transactions, each with a fresh
		// mode. A phase ends between messages, but messages broken off early let
		// mode changes land mid-message as well.
		while (groups_sent < TARGET_GROUPS) begin
			wait_idle();
			write_mode(logic'($urandom_range(0, 1)));
			phase_end = groups_sent + $urandom_range(50, 150);
			while (groups_sent < phase_end && groups_sent < TARGET_GROUPS)
				send_message();
		end

		wait_idle();
		repeat (5) @(posedge clk);

		$display("Checked %0d groups: %0d length headers, %0d characters, %0d pass-through.",
			sb.role_count[ROLE_HEADER] + sb.role_count[ROLE_PAYLOAD] + sb.role_count[ROLE_PASS],
			sb.role_count[ROLE_HEADER], sb.role_count[ROLE_PAYLOAD], sb.role_count[ROLE_PASS]);
		$display("%0d groups in extract mode, %0d mode writes read back, %0d field mismatches.",
			sb.extract_groups, mode_writes, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
